[rtl/hlre_pkg.sv]
`timescale 1ns / 1ps

package hlre_pkg;

    localparam int NODE_W = 4;
    localparam int HOP_W  = 8;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [NODE_W-1:0] row_node;
        logic [NODE_W-1:0] col_node;
        logic              edge_present;
        logic [NODE_W-1:0] source_node;
        logic              source_known;
        logic [HOP_W-1:0]  source_hops;
        logic [NODE_W-1:0] avoid_node;
        logic              avoid_known;
        logic [HOP_W-1:0]  avoid_hops;
    } t_req;

    typedef struct packed {
        logic [NODE_W-1:0] node_index;
        logic              found;
        logic              last;
    } t_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [NODE_W-1:0] wr_row;
        logic [NODE_W-1:0] wr_col;
        logic              wr_bit;
        logic              init;
        logic              src_ok;
        logic [NODE_W-1:0] src;
        logic              avd_ok;
        logic [NODE_W-1:0] avd;
        logic              step_s;
        logic              step_a;
        logic              pop;
    } t_cell_ctl;

endpackage

[rtl/hop_limited_reach_with_exclusion_top.sv]
`timescale 1ns / 1ps
// Bounded-hop reachability with an excluded neighborhood over a NODES-node graph.
// Request channel (i_req_valid / o_req_ready, payload i_req): a write request
// sets or clears one edge row_node -> col_node and gives no response.
// A query request returns every node reachable from source_node by 1 to
// source_hops edges, minus avoid_node and the nodes within avoid_hops of it.
// Response channel (o_rsp_valid / i_rsp_ready, payload o_rsp): one response per
// answer node in ascending order, last marked; an empty answer gives a single
// response with found clear. One cell per node holds that node's incoming edges
// and both walk states; both walks step together, one hop per cycle.
// A query is accepted in ST_IDLE, walks in ST_WALK, then ST_EMIT gives one response per
// cycle while the receiver is ready; o_req_ready is low from the accept until the
// last response is loaded into the output register.
// A stalled receiver holds the output register and freezes the emission.
// Reset clears the edge matrix and all query state.
module hop_limited_reach_with_exclusion_top #(
    parameter int NODES = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  hlre_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output hlre_pkg::t_rsp  o_rsp
);
    import hlre_pkg::*;

    localparam int HOP_CW = $clog2(NODES + 1);
    localparam int IDX_W  = $clog2(NODES);

    t_state            r_state, n_state;
    logic [HOP_CW-1:0] r_src_left, n_src_left;
    logic [HOP_CW-1:0] r_avd_left, n_avd_left;
    logic              r_rsp_valid, n_rsp_valid;
    t_rsp              r_rsp, n_rsp;
    t_cell_ctl         ctl;
    logic [NODES-1:0]  fr_s_vec;
    logic [NODES-1:0]  fr_a_vec;
    logic [NODES-1:0]  ans_vec;
    logic [NODES-1:0]  pick_vec;
    logic [NODES:0]    below;
    logic [IDX_W-1:0]  pick_idx;
    logic              req_fire;
    logic              s_act;
    logic              a_act;
    logic              rest;
    logic              slot_free;

    assign below[0] = 1'b0;

    for (genvar g = 0; g < NODES; g++) begin : g_cell
        hlre_cell #(
            .NODES (NODES),
            .IDX   (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_fr_s_bus (fr_s_vec),
            .i_fr_a_bus (fr_a_vec),
            .i_below    (below[g]),
            .o_below    (below[g+1]),
            .o_fr_s     (fr_s_vec[g]),
            .o_fr_a     (fr_a_vec[g]),
            .o_ans      (ans_vec[g]),
            .o_pick     (pick_vec[g])
        );
    end

    always_comb begin
        pick_idx = '0;
        for (int j = 0; j < NODES; j++) begin
            if (pick_vec[j]) begin
                pick_idx = pick_idx | IDX_W'(j);
            end
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign s_act       = (r_src_left != '0) && (|fr_s_vec);
    assign a_act       = (r_avd_left != '0) && (|fr_a_vec);
    assign rest        = |(ans_vec & ~pick_vec);
    assign slot_free   = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_src_left  = r_src_left;
        n_avd_left  = r_avd_left;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        n_rsp       = r_rsp;
        ctl         = '0;
        ctl.wr_row  = i_req.row_node;
        ctl.wr_col  = i_req.col_node;
        ctl.wr_bit  = i_req.edge_present;
        ctl.src     = i_req.source_node;
        ctl.avd     = i_req.avoid_node;
        ctl.src_ok  = i_req.source_known && (int'(i_req.source_node) < NODES);
        ctl.avd_ok  = i_req.avoid_known && (int'(i_req.avoid_node) < NODES);
        unique case (r_state)
            ST_IDLE: begin
                ctl.wr_en = req_fire && (i_req.kind == KIND_WRITE)
                            && (int'(i_req.row_node) < NODES)
                            && (int'(i_req.col_node) < NODES);
                if (req_fire && (i_req.kind == KIND_QUERY)) begin
                    ctl.init   = 1'b1;
                    n_src_left = (int'(i_req.source_hops) > NODES) ? HOP_CW'(NODES)
                                                                   : HOP_CW'(i_req.source_hops);
                    n_avd_left = (int'(i_req.avoid_hops) > NODES) ? HOP_CW'(NODES)
                                                                  : HOP_CW'(i_req.avoid_hops);
                    n_state    = ST_WALK;
                end
            end
            ST_WALK: begin
                ctl.step_s = s_act;
                ctl.step_a = a_act;
                if (s_act) begin
                    n_src_left = r_src_left - 1'b1;
                end
                if (a_act) begin
                    n_avd_left = r_avd_left - 1'b1;
                end
                if (!s_act && !a_act) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    n_rsp_valid = 1'b1;
                    if (below[NODES]) begin
                        ctl.pop          = 1'b1;
                        n_rsp.node_index = NODE_W'(pick_idx);
                        n_rsp.found      = 1'b1;
                        n_rsp.last       = !rest;
                        if (!rest) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_rsp.node_index = '0;
                        n_rsp.found      = 1'b0;
                        n_rsp.last       = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_src_left  <= '0;
            r_avd_left  <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_src_left  <= n_src_left;
            r_avd_left  <= n_avd_left;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp <= n_rsp;
    end

endmodule

[rtl/hlre_cell.sv]
`timescale 1ns / 1ps

module hlre_cell #(
    parameter int NODES = 16,
    parameter int IDX   = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hlre_pkg::t_cell_ctl   i_ctl,
    input  logic [NODES-1:0]      i_fr_s_bus,
    input  logic [NODES-1:0]      i_fr_a_bus,
    input  logic                  i_below,
    output logic                  o_below,
    output logic                  o_fr_s,
    output logic                  o_fr_a,
    output logic                  o_ans,
    output logic                  o_pick
);
    import hlre_pkg::*;

    logic [NODES-1:0] r_col, n_col;
    logic             r_seen_s, n_seen_s;
    logic             r_fr_s, n_fr_s;
    logic             r_seen_a, n_seen_a;
    logic             r_fr_a, n_fr_a;
    logic             r_aself, n_aself;
    logic             nx_s;
    logic             nx_a;
    logic             ans;
    logic             pick;

    assign nx_s = |(i_fr_s_bus & r_col);
    assign nx_a = |(i_fr_a_bus & r_col);
    assign ans  = r_seen_s & ~r_seen_a & ~r_aself;
    assign pick = ans & ~i_below;

    assign o_below = i_below | ans;
    assign o_fr_s  = r_fr_s;
    assign o_fr_a  = r_fr_a;
    assign o_ans   = ans;
    assign o_pick  = pick;

    always_comb begin
        n_col    = r_col;
        n_seen_s = r_seen_s;
        n_fr_s   = r_fr_s;
        n_seen_a = r_seen_a;
        n_fr_a   = r_fr_a;
        n_aself  = r_aself;
        if (i_ctl.wr_en && (int'(i_ctl.wr_col) == IDX)) begin
            for (int r = 0; r < NODES; r++) begin
                if (int'(i_ctl.wr_row) == r) begin
                    n_col[r] = i_ctl.wr_bit;
                end
            end
        end
        if (i_ctl.init) begin
            n_seen_s = 1'b0;
            n_fr_s   = i_ctl.src_ok && (int'(i_ctl.src) == IDX);
            n_seen_a = 1'b0;
            n_fr_a   = i_ctl.avd_ok && (int'(i_ctl.avd) == IDX);
            n_aself  = i_ctl.avd_ok && (int'(i_ctl.avd) == IDX);
        end else begin
            if (i_ctl.step_s) begin
                n_fr_s   = nx_s & ~r_seen_s;
                n_seen_s = r_seen_s | nx_s;
            end
            if (i_ctl.step_a) begin
                n_fr_a   = nx_a & ~r_seen_a;
                n_seen_a = r_seen_a | nx_a;
            end
            if (i_ctl.pop && pick) begin
                n_seen_s = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_seen_s <= 1'b0;
            r_fr_s   <= 1'b0;
            r_seen_a <= 1'b0;
            r_fr_a   <= 1'b0;
            r_aself  <= 1'b0;
        end else begin
            r_col    <= n_col;
            r_seen_s <= n_seen_s;
            r_fr_s   <= n_fr_s;
            r_seen_a <= n_seen_a;
            r_fr_a   <= n_fr_a;
            r_aself  <= n_aself;
        end
    end

endmodule

[rtl/hlre_checker.sv]
`timescale 1ns / 1ps

module hlre_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            o_req_ready,
    input hlre_pkg::t_req  i_req,
    input logic            o_rsp_valid,
    input logic            i_rsp_ready,
    input hlre_pkg::t_rsp  o_rsp
);
    import hlre_pkg::*;

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && (i_req.kind == KIND_QUERY)) |=> !o_req_ready)
        else $error("ready stayed high after a query request");

    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && (i_req.kind == KIND_WRITE)) |=> o_req_ready)
        else $error("write request left the block busy");

    a_empty_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.found) |-> (o_rsp.last && (o_rsp.node_index == '0)))
        else $error("empty answer response is malformed");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !i_rsp_ready) |=> (o_rsp_valid && $stable(o_rsp)))
        else $error("stalled response changed");

endmodule

bind hop_limited_reach_with_exclusion_top hlre_checker u_hlre_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import hlre_pkg::*;

    localparam int NODES       = 16;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 300000;
    localparam int ROUND_LEN   = 52;

    typedef struct packed {
        t_req req;
        logic typed;
        t_rsp want;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    logic [NODES-1:0] edge_rows [NODES];
    t_rsp             pending_nodes [$];
    t_stim_row        stim_rows [$];
    int               mismatches = 0;
    int unsigned      cycle_count = 0;
    bit               quiet = 1'b0;
    bit               hold_off_request = 1'b0;

    hop_limited_reach_with_exclusion_top #(
        .NODES(NODES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req      (i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp      (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_rsp rsp_item(logic [NODE_W-1:0] node, logic found, logic last);
        t_rsp r;
        r.node_index = node;
        r.found      = found;
        r.last       = last;
        return r;
    endfunction

    function automatic t_req random_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(t_req)-1:0];
    endfunction

    function automatic t_req write_req(int row, int col, logic present);
        t_req r;
        r              = random_fields();
        r.kind         = KIND_WRITE;
        r.row_node     = NODE_W'(row);
        r.col_node     = NODE_W'(col);
        r.edge_present = present;
        return r;
    endfunction

    function automatic t_req query_req(int src, logic src_ok, int src_hops,
                                       int avd, logic avd_ok, int avd_hops);
        t_req r;
        r              = random_fields();
        r.kind         = KIND_QUERY;
        r.source_node  = NODE_W'(src);
        r.source_known = src_ok;
        r.source_hops  = HOP_W'(src_hops);
        r.avoid_node   = NODE_W'(avd);
        r.avoid_known  = avd_ok;
        r.avoid_hops   = HOP_W'(avd_hops);
        return r;
    endfunction

    function automatic logic [HOP_W-1:0] random_hops();
        if ($urandom_range(0, 3) == 0)
            return HOP_W'($urandom_range(0, 255));
        return HOP_W'($urandom_range(0, NODES + 1));
    endfunction

    function automatic t_req random_request(int set_pct);
        t_req r;
        r = random_fields();
        if ($urandom_range(0, 1) == 0) begin
            r.kind         = KIND_WRITE;
            r.edge_present = ($urandom_range(0, 99) < set_pct);
        end else begin
            r.kind         = KIND_QUERY;
            r.source_known = ($urandom_range(0, 9) != 0);
            r.source_hops  = random_hops();
            r.avoid_hops   = random_hops();
        end
        return r;
    endfunction

    // Nodes reached from start by a walk of 1 to hops edges.
    function automatic logic [NODES-1:0] hop_reach(logic [NODE_W-1:0] start,
                                                   logic [HOP_W-1:0] hops);
        logic [NODES-1:0] seen;
        logic [NODES-1:0] frontier;
        logic [NODES-1:0] next_set;
        int               limit;
        seen     = '0;
        frontier = '0;
        frontier[start] = 1'b1;
        limit    = (hops > NODES) ? NODES : hops;
        for (int s = 0; s < limit && frontier != '0; s++) begin
            next_set = '0;
            for (int i = 0; i < NODES; i++)
                if (frontier[i])
                    next_set |= edge_rows[i];
            frontier = next_set & ~seen;
            seen     |= next_set;
        end
        return seen;
    endfunction

    task automatic apply_request(input t_req r);
        logic [NODES-1:0] reach;
        logic [NODES-1:0] excluded;
        logic [NODES-1:0] answer;
        if (r.kind == KIND_WRITE) begin
            edge_rows[r.row_node][r.col_node] = r.edge_present;
        end else begin
            reach    = r.source_known ? hop_reach(r.source_node, r.source_hops) : '0;
            excluded = '0;
            if (r.avoid_known) begin
                excluded = hop_reach(r.avoid_node, r.avoid_hops);
                excluded[r.avoid_node] = 1'b1;
            end
            answer = reach & ~excluded;
            if (answer == '0) begin
                pending_nodes.push_back(rsp_item('0, 1'b0, 1'b1));
            end else begin
                for (int i = 0; i < NODES; i++) begin
                    if (answer[i]) begin
                        answer[i] = 1'b0;
                        pending_nodes.push_back(rsp_item(NODE_W'(i), 1'b1, answer == '0));
                    end
                end
            end
        end
    endtask

    task automatic add_row(input t_req r, input logic typed, input t_rsp want);
        t_stim_row row;
        row.req   = r;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    task automatic send_request(input t_req r);
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (o_req_ready !== 1'b1)
            @(posedge i_clk);
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic note_mismatch(input string what, input t_rsp want, input t_rsp got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: expected node %0d found %0b last %0b, got node %0d found %0b last %0b",
                     $time, what, want.node_index, want.found, want.last,
                     got.node_index, got.found, got.last);
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (pending_nodes.size() == 0) begin
                note_mismatch("unexpected response", '0, o_rsp);
            end else begin
                want = pending_nodes.pop_front();
                if (o_rsp.node_index !== want.node_index || o_rsp.found !== want.found
                    || o_rsp.last !== want.last)
                    note_mismatch("response mismatch", want, o_rsp);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    initial begin
        i_rsp_ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                i_rsp_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_rsp_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_rsp_ready <= 1'b1;
            end
        end
    end

    initial begin
        int set_pct [4];
        t_stim_row row;
        set_pct = '{30, 60, 85, 50};
        i_rst_n     = 1'b0;
        i_req_valid = 1'b0;
        i_req       = '0;
        for (int i = 0; i < NODES; i++)
            edge_rows[i] = '0;

        add_row(query_req(0, 1, 16, 0, 0, 0), 1'b1, rsp_item(0, 0, 1));
        add_row(write_req(0, 15, 1), 1'b0, '0);
        add_row(write_req(15, 0, 1), 1'b0, '0);
        add_row(query_req(0, 1, 1, 0, 0, 255), 1'b1, rsp_item(15, 1, 1));
        add_row(query_req(0, 1, 255, 0, 0, 0), 1'b0, '0);
        add_row(query_req(0, 1, 0, 3, 0, 0), 1'b1, rsp_item(0, 0, 1));
        add_row(query_req(0, 0, 16, 3, 0, 0), 1'b1, rsp_item(0, 0, 1));
        add_row(query_req(0, 1, 2, 15, 1, 0), 1'b0, '0);
        add_row(query_req(0, 1, 255, 0, 1, 255), 1'b1, rsp_item(0, 0, 1));
        add_row(query_req(15, 1, 255, 15, 0, 255), 1'b0, '0);
        add_row(write_req(15, 0, 0), 1'b0, '0);
        add_row(write_req(1, 2, 1), 1'b0, '0);
        add_row(write_req(2, 3, 1), 1'b0, '0);
        add_row(write_req(3, 4, 1), 1'b0, '0);
        add_row(write_req(4, 5, 1), 1'b0, '0);
        add_row(query_req(1, 1, 2, 0, 0, 0), 1'b0, '0);
        add_row(query_req(1, 1, 3, 3, 1, 1), 1'b0, '0);
        add_row(query_req(1, 1, 255, 2, 1, 255), 1'b1, rsp_item(0, 0, 1));
        add_row(write_req(5, 1, 1), 1'b0, '0);
        add_row(query_req(1, 1, 255, 9, 1, 255), 1'b0, '0);
        add_row(query_req(15, 1, 1, 0, 0, 0), 1'b1, rsp_item(0, 0, 1));
        add_row(query_req(0, 1, 1, 15, 1, 0), 1'b1, rsp_item(0, 0, 1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[n]) begin
            row = stim_rows[n];
            send_request(row.req);
            if (row.typed)
                pending_nodes.push_back(row.want);
            else
                apply_request(row.req);
            sender_gap();
        end

        for (int round = 0; round < 4; round++) begin
            if (round == 1)
                hold_off_request = 1'b1;
            if (round == 2) begin
                i_req_valid <= 1'b0;
                wait (pending_nodes.size() == 0);
                @(posedge i_clk);
            end
            if (round == 3)
                quiet = 1'b1;
            for (int k = 0; k < ROUND_LEN; k++) begin
                t_req r;
                r = random_request(set_pct[round]);
                send_request(r);
                apply_request(r);
                sender_gap();
            end
        end
        i_req_valid <= 1'b0;

        wait (pending_nodes.size() == 0);
        repeat (2 * NODES + 8) @(posedge i_clk);
        if (mismatches == 0 && pending_nodes.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
